@@ sv/sstf_pkg.sv @@
// Shared types and constants for the shortest-seek-first scheduler.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none
package sstf_pkg;

  // Field widths fixed at the block's ports
  localparam int unsigned CYL_PORT_W = 12;
  localparam int unsigned MOVE_W     = 17;
  localparam int unsigned TIME_W     = 21;
  localparam int unsigned RATE_W     = 4;

  localparam logic [RATE_W-1:0] SEEK_RATE_RESET = 4'd5;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_WAIT  = 5'b00100,
    ST_SERVE = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // accept one request transaction
    logic scan_start;  // rewind scan pointer, clear best candidate
    logic scan_en;     // read one queue entry this cycle
    logic serve;       // retire best candidate, move head
    logic emit;        // register one result transaction
    logic finish;      // end of batch, empty the queue
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_last;      // pointer is on the last loaded entry
    logic pending_empty;  // no request left in this batch
  } status_t;

endpackage
`default_nettype wire

@@ sv/shortest_seek_first_scheduler_core.sv @@
// Top level: shortest-seek-first disk request scheduler; depends on sstf_pkg, sstf_ctrl, sstf_dp.
// A request transaction without batch_end is accepted and gives no result.
// After batch_end, each result is found by a scan of all N stored requests, one entry per
// cycle, then served and emitted; busy stays high until the last result is emitted.
// Each result is strobed for one cycle on out_valid; the receiver cannot stall it.
// Reset (rst_n low, synchronous) empties the queue, zeroes head and totals, sets rate 5.
`default_nettype none
module shortest_seek_first_scheduler_core #(
  parameter int unsigned QUEUE_DEPTH   = 32,
  parameter int unsigned CYLINDER_BITS = 12
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [sstf_pkg::CYL_PORT_W-1:0]  in_request_cylinder,
  input  wire logic [sstf_pkg::CYL_PORT_W-1:0]  in_start_head,
  input  wire logic                             in_batch_end,
  output logic                                  out_valid,
  output logic [sstf_pkg::CYL_PORT_W-1:0]       out_served_cylinder,
  output logic [sstf_pkg::MOVE_W-1:0]           out_head_movement_total,
  output logic [sstf_pkg::TIME_W-1:0]           out_seek_time_total,
  output logic                                  out_dropped_flag,
  output logic                                  out_final_result,
  input  wire logic                             cfg_we,
  input  wire logic [sstf_pkg::RATE_W-1:0]      cfg_data
);
  import sstf_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  sstf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .batch_end (in_batch_end),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  // queue, scan and totals
  sstf_dp #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .CYLINDER_BITS (CYLINDER_BITS)
  ) u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (cmd),
    .status                  (status),
    .in_request_cylinder     (in_request_cylinder),
    .in_start_head           (in_start_head),
    .cfg_we                  (cfg_we),
    .cfg_data                (cfg_data),
    .out_valid               (out_valid),
    .out_served_cylinder     (out_served_cylinder),
    .out_head_movement_total (out_head_movement_total),
    .out_seek_time_total     (out_seek_time_total),
    .out_dropped_flag        (out_dropped_flag),
    .out_final_result        (out_final_result)
  );

endmodule
`default_nettype wire

@@ sv/sstf_ctrl.sv @@
// Sequencer for the scheduler: load, scan, serve and emit phases.
// Depends on sstf_pkg for state, command and status types.
`default_nettype none
module sstf_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic            batch_end,
  input  sstf_pkg::status_t    status,
  output sstf_pkg::cmd_t       cmd,
  output logic                 busy
);
  import sstf_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (batch_end) begin
            cmd.scan_start = 1'b1;
            state_nxt      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (status.scan_last) begin
          state_nxt = ST_WAIT;
        end
      end
      // last read entry is compared in this cycle
      ST_WAIT: begin
        state_nxt = ST_SERVE;
      end
      ST_SERVE: begin
        cmd.serve = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (status.pending_empty) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule
`default_nettype wire

@@ sv/sstf_dp.sv @@
// Datapath: request memory, pending bits, nearest-request scan, head and totals.
// Depends on sstf_pkg for command/status types and field widths.
`default_nettype none
module sstf_dp #(
  parameter int unsigned QUEUE_DEPTH   = 32,
  parameter int unsigned CYLINDER_BITS = 12
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  sstf_pkg::cmd_t                        cmd,
  output sstf_pkg::status_t                     status,
  input  wire logic [sstf_pkg::CYL_PORT_W-1:0]  in_request_cylinder,
  input  wire logic [sstf_pkg::CYL_PORT_W-1:0]  in_start_head,
  input  wire logic                             cfg_we,
  input  wire logic [sstf_pkg::RATE_W-1:0]      cfg_data,
  output logic                                  out_valid,
  output logic [sstf_pkg::CYL_PORT_W-1:0]       out_served_cylinder,
  output logic [sstf_pkg::MOVE_W-1:0]           out_head_movement_total,
  output logic [sstf_pkg::TIME_W-1:0]           out_seek_time_total,
  output logic                                  out_dropped_flag,
  output logic                                  out_final_result
);
  import sstf_pkg::*;

  localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CB = CYLINDER_BITS;

  // storage
  logic [CB-1:0]          mem [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] pending_r, pending_nxt;
  logic [CW-1:0]          count_r;
  logic [CB-1:0]          head_r;
  logic [MOVE_W-1:0]      move_r;
  logic                   ovf_r;
  logic [RATE_W-1:0]      rate_r;

  // scan pipeline and best candidate
  logic [IW-1:0]          scan_idx_r;
  logic [IW-1:0]          cmp_idx_r;
  logic                   cmp_vld_r;
  logic [CB-1:0]          rd_data_r;
  logic                   found_r;
  logic [CB-1:0]          best_dist_r;
  logic [CB-1:0]          best_cyl_r;
  logic [IW-1:0]          best_idx_r;

  logic [CB-1:0]          cyl_in;
  logic [CB-1:0]          head_in;
  logic                   has_room;
  logic [CW-1:0]          cnt_m1;
  logic [CB-1:0]          seek_dist;
  logic                   take;
  logic [MOVE_W-1:0]      best_dist_ext;

  // input fields sized to CYLINDER_BITS
  assign cyl_in   = CB'(in_request_cylinder);
  assign head_in  = CB'(in_start_head);
  assign has_room = (count_r < CW'(QUEUE_DEPTH));
  assign cnt_m1   = count_r - CW'(1);

  assign status.scan_last     = (scan_idx_r == cnt_m1[IW-1:0]);
  assign status.pending_empty = (pending_r == '0);

  // distance of the entry under compare and candidate update
  assign seek_dist = (head_r > rd_data_r) ? (head_r - rd_data_r) : (rd_data_r - head_r);
  assign take = cmp_vld_r && pending_r[cmp_idx_r] &&
                (!found_r || (seek_dist < best_dist_r));
  assign best_dist_ext = MOVE_W'(best_dist_r);

  // pending bits for a load transaction
  always_comb begin
    pending_nxt = (count_r == '0) ? '0 : pending_r;
    if (has_room) begin
      pending_nxt[count_r[IW-1:0]] = 1'b1;
    end
  end

  // request memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load && has_room) begin
      mem[count_r[IW-1:0]] <= cyl_in;
    end
    if (cmd.scan_en) begin
      rd_data_r <= mem[scan_idx_r];
    end
  end

  // control state of the batch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      count_r   <= '0;
      head_r    <= '0;
      move_r    <= '0;
      ovf_r     <= 1'b0;
      rate_r    <= SEEK_RATE_RESET;
      out_valid <= 1'b0;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        rate_r <= cfg_data;
      end
      // load one request
      if (cmd.load) begin
        pending_r <= pending_nxt;
        if (count_r == '0) begin
          head_r <= head_in;
          move_r <= '0;
          ovf_r  <= ~has_room;
        end else if (!has_room) begin
          ovf_r <= 1'b1;
        end
        if (has_room) begin
          count_r <= count_r + CW'(1);
        end
      end
      // retire the nearest request
      if (cmd.serve) begin
        pending_r[best_idx_r] <= 1'b0;
        move_r                <= move_r + best_dist_ext;
        head_r                <= best_cyl_r;
      end
      if (cmd.finish) begin
        pending_r <= '0;
        count_r   <= '0;
      end
      cmp_vld_r <= cmd.scan_en;
      if (cmd.scan_start) begin
        found_r <= 1'b0;
      end else if (take) begin
        found_r <= 1'b1;
      end
      out_valid <= cmd.emit;
    end
  end

  // scan pointer and best candidate payload
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx_r <= '0;
    end else if (cmd.scan_en) begin
      scan_idx_r <= scan_idx_r + IW'(1);
    end
    cmp_idx_r <= scan_idx_r;
    if (take) begin
      best_dist_r <= seek_dist;
      best_cyl_r  <= rd_data_r;
      best_idx_r  <= cmp_idx_r;
    end
  end

  // result registers; product kept at full seek-time width
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_served_cylinder     <= CYL_PORT_W'(head_r);
      out_head_movement_total <= move_r;
      out_seek_time_total     <= TIME_W'(move_r) * TIME_W'(rate_r);
      out_dropped_flag        <= ovf_r;
      out_final_result        <= (pending_r == '0);
    end
  end

endmodule
`default_nettype wire

@@ tb/tb_shortest_seek_first_scheduler_core.sv @@
// Self-checking testbench for shortest_seek_first_scheduler_core: request batches in,
// served cylinders and running seek totals out, checked against an in-bench SSTF predictor.
// Depends on sstf_pkg and the scheduler RTL; needs no files or arguments.
`default_nettype none
module tb_shortest_seek_first_scheduler_core;
  timeunit 1ns;
  timeprecision 1ps;
  import sstf_pkg::*;

  localparam int unsigned QUEUE_DEPTH   = 32;
  localparam int unsigned CYLINDER_BITS = 12;

  // One served request as seen on the result ports
  typedef struct packed {
    logic [CYL_PORT_W-1:0] cylinder;
    logic [MOVE_W-1:0]     travel;
    logic [TIME_W-1:0]     seek_time;
    logic                  dropped;
    logic                  last_served;
  } service_t;

  // How the cylinders of a random batch are spread
  typedef enum int {SPREAD_UNIFORM, SPREAD_CLUSTER, SPREAD_EDGES} spread_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [CYL_PORT_W-1:0] in_request_cylinder = '0;
  logic [CYL_PORT_W-1:0] in_start_head = '0;
  logic                  in_batch_end = 1'b0;
  logic                  out_valid;
  logic [CYL_PORT_W-1:0] out_served_cylinder;
  logic [MOVE_W-1:0]     out_head_movement_total;
  logic [TIME_W-1:0]     out_seek_time_total;
  logic                  out_dropped_flag;
  logic                  out_final_result;
  logic                  cfg_we = 1'b0;
  logic [RATE_W-1:0]     cfg_data = '0;

  shortest_seek_first_scheduler_core #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .CYLINDER_BITS(CYLINDER_BITS)
  ) dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_request_cylinder    (in_request_cylinder),
    .in_start_head          (in_start_head),
    .in_batch_end           (in_batch_end),
    .out_valid              (out_valid),
    .out_served_cylinder    (out_served_cylinder),
    .out_head_movement_total(out_head_movement_total),
    .out_seek_time_total    (out_seek_time_total),
    .out_dropped_flag       (out_dropped_flag),
    .out_final_result       (out_final_result),
    .cfg_we                 (cfg_we),
    .cfg_data               (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Scheduler state mirrored by the predictor
  logic [CYL_PORT_W-1:0]  queued_cyl [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] queued_pending = '0;
  int unsigned            queued_count = 0;
  logic [CYL_PORT_W-1:0]  head_cyl = '0;
  logic [MOVE_W-1:0]      travel_sum = '0;
  logic                   overflow_hit = 1'b0;
  logic [RATE_W-1:0]      seek_rate = SEEK_RATE_RESET;

  service_t    service_order_q[$];
  int unsigned mismatches = 0;
  int unsigned requests_sent = 0;
  bit          sender_gaps = 1'b1;

  // Work out the services caused by one accepted request transaction
  function automatic void predict_services(input logic [CYL_PORT_W-1:0] cyl,
                                           input logic [CYL_PORT_W-1:0] head,
                                           input logic last);
    int unsigned           best_idx;
    logic [CYL_PORT_W-1:0] best_d;
    logic [CYL_PORT_W-1:0] d;
    bit                    found;
    service_t              svc;
    logic [31:0]           product;
    if (queued_count == 0) begin
      head_cyl       = head;
      travel_sum     = '0;
      overflow_hit   = 1'b0;
      queued_pending = '0;
    end
    if (queued_count < QUEUE_DEPTH) begin
      queued_cyl[queued_count]     = cyl;
      queued_pending[queued_count] = 1'b1;
      queued_count++;
    end else begin
      overflow_hit = 1'b1;
    end
    if (!last) return;
    while (queued_pending != '0) begin
      found    = 1'b0;
      best_idx = 0;
      best_d   = '0;
      // nearest pending entry; strict compare keeps the earliest on a tie
      for (int unsigned i = 0; i < queued_count; i++) begin
        if (queued_pending[i]) begin
          d = (head_cyl > queued_cyl[i]) ? head_cyl - queued_cyl[i]
                                         : queued_cyl[i] - head_cyl;
          if (!found || d < best_d) begin
            found    = 1'b1;
            best_d   = d;
            best_idx = i;
          end
        end
      end
      queued_pending[best_idx] = 1'b0;
      travel_sum = travel_sum + MOVE_W'(best_d);
      head_cyl   = queued_cyl[best_idx];
      product    = 32'(travel_sum) * 32'(seek_rate);
      svc.cylinder    = head_cyl;
      svc.travel      = travel_sum;
      svc.seek_time   = product[TIME_W-1:0];
      svc.dropped     = overflow_hit;
      svc.last_served = (queued_pending == '0);
      service_order_q.insert(service_order_q.size(), svc);
    end
    queued_count = 0;
  endfunction

  // Result checker: strobe sampled mid-cycle, compared with the oldest prediction
  always @(negedge clk) begin : check_services
    service_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (service_order_q.size() == 0) begin
        $error("unexpected result transaction: served_cylinder %0d", out_served_cylinder);
        mismatches++;
      end else begin
        want = service_order_q.pop_front();
        if (out_served_cylinder !== want.cylinder) begin
          $error("served_cylinder: expected %0d, got %0d", want.cylinder, out_served_cylinder);
          mismatches++;
        end
        if (out_head_movement_total !== want.travel) begin
          $error("head_movement_total: expected %0d, got %0d",
                 want.travel, out_head_movement_total);
          mismatches++;
        end
        if (out_seek_time_total !== want.seek_time) begin
          $error("seek_time_total: expected %0d, got %0d", want.seek_time, out_seek_time_total);
          mismatches++;
        end
        if (out_dropped_flag !== want.dropped) begin
          $error("dropped_flag: expected %0b, got %0b", want.dropped, out_dropped_flag);
          mismatches++;
        end
        if (out_final_result !== want.last_served) begin
          $error("final_result: expected %0b, got %0b", want.last_served, out_final_result);
          mismatches++;
        end
      end
    end
  end

  // Send one request transaction; entered and left just after a rising edge.
  // start stays high on exit so back-to-back requests never drop it.
  task automatic send_request(input logic [CYL_PORT_W-1:0] cyl,
                              input logic [CYL_PORT_W-1:0] head,
                              input logic last);
    bit taken;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    start               <= 1'b1;
    in_request_cylinder <= cyl;
    in_start_head       <= head;
    in_batch_end        <= last;
    taken = 1'b0;
    // busy is stable at the falling edge, so this decides the coming rising edge
    while (!taken) begin
      @(negedge clk);
      taken = (busy === 1'b0);
      @(posedge clk);
    end
    predict_services(cyl, head, last);
    requests_sent++;
  endtask

  // Hold the sender until every predicted result has come and the block is idle
  task automatic wait_for_drain();
    start <= 1'b0;
    do @(posedge clk); while (service_order_q.size() != 0);
    repeat (4) @(posedge clk);
    @(negedge clk);
    while (busy !== 1'b0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_seek_rate(input logic [RATE_W-1:0] rate);
    wait_for_drain();
    cfg_we   <= 1'b1;
    cfg_data <= rate;
    @(posedge clk);
    cfg_we    <= 1'b0;
    seek_rate = rate;
  endtask

  // One well-formed batch of random content; start_head varies on later items too
  task automatic run_random_batch(input int unsigned size);
    spread_t               spread;
    logic [CYL_PORT_W-1:0] center;
    logic [CYL_PORT_W-1:0] head;
    logic [CYL_PORT_W-1:0] cyl;
    spread = spread_t'($urandom_range(0, 2));
    center = CYL_PORT_W'($urandom);
    head   = $urandom_range(0, 1) ? center : CYL_PORT_W'($urandom);
    for (int unsigned i = 0; i < size; i++) begin
      case (spread)
        SPREAD_UNIFORM: cyl = CYL_PORT_W'($urandom);
        // tight cluster around one center makes equal distances common
        SPREAD_CLUSTER: cyl = CYL_PORT_W'(center + $urandom_range(0, 6) - 3);
        default: begin
          case ($urandom_range(0, 2))
            0:       cyl = '1;
            1:       cyl = '0;
            default: cyl = CYL_PORT_W'($urandom);
          endcase
        end
      endcase
      send_request(cyl, (i == 0) ? head : CYL_PORT_W'($urandom), i == size - 1);
    end
  endtask

  function automatic int unsigned pick_batch_size();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 6);
    if (r < 19) return $urandom_range(7, QUEUE_DEPTH - 1);
    return $urandom_range(QUEUE_DEPTH, QUEUE_DEPTH + 4);
  endfunction

  // Default rate after reset, one-request batches at the far ends and one at the head
  task automatic test_reset_defaults();
    send_request(12'd4095, 12'd0, 1'b1);
    send_request(12'd0, 12'd4095, 1'b1);
    send_request(12'd1234, 12'd1234, 1'b1);
  endtask

  // Equal distances: earliest loaded request wins
  task automatic test_equal_distances();
    send_request(12'd90, 12'd100, 1'b0);
    send_request(12'd110, 12'd0, 1'b0);
    send_request(12'd90, 12'd4095, 1'b1);
    send_request(12'd2058, 12'd2048, 1'b0);
    send_request(12'd2038, 12'd0, 1'b0);
    send_request(12'd2048, 12'd0, 1'b1);
  endtask

  // Field extremes and alternating bit patterns; start_head ignored after the first item
  task automatic test_field_extremes();
    send_request(12'd0, 12'd4095, 1'b0);
    send_request(12'd4095, 12'd0, 1'b0);
    send_request(12'hAAA, 12'h555, 1'b0);
    send_request(12'h555, 12'hAAA, 1'b1);
  endtask

  // Extreme rates, including zero, which is used as given
  task automatic test_seek_rates();
    write_seek_rate(4'd15);
    send_request(12'd4095, 12'd0, 1'b0);
    send_request(12'd0, 12'd0, 1'b0);
    send_request(12'd4095, 12'd0, 1'b1);
    write_seek_rate(4'd1);
    send_request(12'd0, 12'd2048, 1'b0);
    send_request(12'd4095, 12'd2048, 1'b1);
    write_seek_rate(4'd0);
    send_request(12'd1000, 12'd7, 1'b1);
    write_seek_rate(SEEK_RATE_RESET);
  endtask

  // Random batches with random rate changes and sender idling
  task automatic test_random_batches();
    int unsigned stop_at;
    bit          paused;
    stop_at = requests_sent + 80;
    paused  = 1'b0;
    while (requests_sent < stop_at) begin
      if ($urandom_range(0, 3) == 0) write_seek_rate(RATE_W'($urandom));
      sender_gaps = ($urandom_range(0, 3) != 0);
      run_random_batch(pick_batch_size());
      // at least once, let every result come home before going on
      if (!paused && requests_sent >= stop_at - 40) begin
        wait_for_drain();
        paused = 1'b1;
      end
    end
    sender_gaps = 1'b1;
  endtask

  // Batches longer than the queue: extras dropped, last one still triggers service
  task automatic test_queue_overflow();
    run_random_batch(QUEUE_DEPTH + 1);
    write_seek_rate(4'd15);
    run_random_batch(QUEUE_DEPTH + 6);
  endtask

  // Final stretch with no sender idling
  task automatic test_back_to_back();
    int unsigned stop_at;
    write_seek_rate(RATE_W'($urandom));
    sender_gaps = 1'b0;
    stop_at = requests_sent + 30;
    while (requests_sent < stop_at) run_random_batch($urandom_range(1, 5));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_equal_distances();
    test_field_extremes();
    test_seek_rates();
    test_random_batches();
    test_queue_overflow();
    test_back_to_back();
    start <= 1'b0;
    while (service_order_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (service_order_q.size() != 0) begin
      $error("%0d predicted results never arrived", service_order_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire
